FILE: hw/rtl/cqfn_pkg.sv
`default_nettype none

package cqfn_pkg;

  // Deepest quadtree level below the six root faces.
  localparam int MAX_DEPTH = 8;
  localparam int FACE_W    = 19;
  localparam int COORD_W   = MAX_DEPTH;
  localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
  localparam int ROOT_W    = 3;
  localparam int NUM_ROOTS = 6;
  localparam int NUM_DIRS  = 4;

  typedef logic [FACE_W-1:0]  face_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ROOT_W-1:0]  root_t;

  // Where the row or column of a face across a cube edge comes from.
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_ROW,
    SRC_COL,
    SRC_LAST,
    SRC_ROW_REV,
    SRC_COL_REV
  } src_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_RIGHT,
    DIR_LEFT
  } dir_t;

  typedef struct packed {
    root_t root;
    src_t  row_src;
    src_t  col_src;
  } edge_hop_t;

  localparam edge_hop_t HOP_PAD = '{root: 3'd0, row_src: SRC_ZERO, col_src: SRC_ZERO};

  // Adjacent root and coordinate sources for each direction and root face.
  // Roots six and seven cannot occur and read as padding.
  localparam edge_hop_t HOP_TABLE [NUM_DIRS][8] = '{
    '{ '{3'd2, SRC_COL_REV, SRC_LAST}, '{3'd2, SRC_COL, SRC_ZERO},
       '{3'd5, SRC_ZERO, SRC_COL_REV}, '{3'd4, SRC_LAST, SRC_COL},
       '{3'd2, SRC_LAST, SRC_COL},     '{3'd2, SRC_ZERO, SRC_COL_REV},
       HOP_PAD, HOP_PAD },
    '{ '{3'd3, SRC_COL, SRC_LAST},     '{3'd3, SRC_COL_REV, SRC_ZERO},
       '{3'd4, SRC_ZERO, SRC_COL},     '{3'd5, SRC_LAST, SRC_COL_REV},
       '{3'd3, SRC_ZERO, SRC_COL},     '{3'd3, SRC_LAST, SRC_COL_REV},
       HOP_PAD, HOP_PAD },
    '{ '{3'd4, SRC_ROW, SRC_LAST},     '{3'd5, SRC_ROW, SRC_LAST},
       '{3'd1, SRC_ZERO, SRC_ROW},     '{3'd1, SRC_LAST, SRC_ROW_REV},
       '{3'd1, SRC_ROW, SRC_LAST},     '{3'd0, SRC_ROW, SRC_LAST},
       HOP_PAD, HOP_PAD },
    '{ '{3'd5, SRC_ROW, SRC_ZERO},     '{3'd4, SRC_ROW, SRC_ZERO},
       '{3'd0, SRC_ZERO, SRC_ROW_REV}, '{3'd0, SRC_LAST, SRC_ROW},
       '{3'd0, SRC_ROW, SRC_ZERO},     '{3'd1, SRC_ROW, SRC_ZERO},
       HOP_PAD, HOP_PAD }
  };

  // First face index of a level: 2 * (4^level - 1).
  function automatic face_t level_base(input int unsigned lvl);
    logic [31:0] v;
    v = ((32'd1 << (2 * lvl)) - 32'd1) << 1;
    return v[FACE_W-1:0];
  endfunction

  localparam face_t FACE_COUNT = level_base(MAX_DEPTH + 1);

  // Mask of the coordinate bits that are live at a level.
  function automatic coord_t level_mask(input lvl_t lvl);
    return ~({COORD_W{1'b1}} << lvl);
  endfunction

  typedef struct packed {
    root_t  root;
    coord_t row;
    coord_t col;
  } cell_t;

  typedef struct packed {
    face_t face;
    lvl_t  level;
    logic  bad;
  } lvl_stage_t;

  typedef struct packed {
    cell_t tile;
    lvl_t  level;
    logic  bad;
  } split_stage_t;

  typedef struct packed {
    cell_t [NUM_DIRS-1:0] nbr;
    lvl_t                 level;
    logic                 bad;
  } nbr_stage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cube_quadtree_face_neighbors.sv
// Neighbor lookup for faces of a cube-map quadtree. Faces 0 to 5 are the
// cube roots and child c of face p is 6 + 4p + c.
// Input channel: in_valid/in_ready carries one face_id per item.
// Output channel: out_valid/out_ready carries one result item per input:
// the up, down, right and left neighbor faces at the same level, and
// bad_index, which is set (with all neighbors zero) when face_id is at or
// above the total face count of all levels down to the deepest one.
// The block is a four-stage pipeline: level search, split into root, row
// and column, one step in each direction with cube edge crossing, and
// reassembly of the face indices. Each stage registers its result; one
// item is accepted every cycle while the output flows.
// When the receiver holds out_ready low, each full stage keeps its item and
// in_ready falls once the stage behind it is full too; nothing is dropped.
// Reset empties the pipeline; there is no other state and no setup.
`default_nettype none

module cube_quadtree_face_neighbors import cqfn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  face_t face_id,
  output logic  out_valid,
  input  logic  out_ready,
  output face_t up_face,
  output face_t down_face,
  output face_t right_face,
  output face_t left_face,
  output logic  bad_index
);

  logic                 lvl_valid;
  logic                 lvl_ready;
  lvl_stage_t           lvl_data;
  logic                 split_valid;
  logic                 split_ready;
  split_stage_t         split_data;
  logic                 step_valid;
  logic                 step_ready;
  nbr_stage_t           step_data;
  face_t [NUM_DIRS-1:0] nbr_face;

  cqfn_level u_level (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .face_id   (face_id),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_data  (lvl_data)
  );

  cqfn_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lvl_valid),
    .in_ready  (lvl_ready),
    .in_data   (lvl_data),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  cqfn_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (step_valid),
    .out_ready (step_ready),
    .out_data  (step_data)
  );

  cqfn_compose u_compose (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (step_valid),
    .in_ready  (step_ready),
    .in_data   (step_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .nbr_face  (nbr_face),
    .bad       (bad_index)
  );

  assign up_face    = nbr_face[DIR_UP];
  assign down_face  = nbr_face[DIR_DOWN];
  assign right_face = nbr_face[DIR_RIGHT];
  assign left_face  = nbr_face[DIR_LEFT];

  // A bad item carries all-zero neighbors.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_index |->
      up_face == '0 && down_face == '0 && right_face == '0 && left_face == '0)
    else $error("bad item carries nonzero neighbors");

  // A good item's neighbors are valid face indices.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_index |->
      up_face < FACE_COUNT && down_face < FACE_COUNT &&
      right_face < FACE_COUNT && left_face < FACE_COUNT)
    else $error("neighbor face index out of range");

  // An output item held back by the receiver is still offered next cycle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(up_face) && $stable(bad_index))
    else $error("stalled output item changed");

endmodule

`default_nettype wire

FILE: hw/rtl/cqfn_level.sv
`default_nettype none

module cqfn_level import cqfn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  face_t      face_id,
  output logic       out_valid,
  input  logic       out_ready,
  output lvl_stage_t out_data
);

  lvl_t level_next;
  logic bad_next;

  // The level is the number of nonzero level start indices at or below the face.
  always_comb begin
    level_next = '0;
    for (int k = 1; k <= MAX_DEPTH; k++) begin
      if (face_id >= level_base(k)) begin
        level_next = LVL_W'(k);
      end
    end
    bad_next = (face_id >= FACE_COUNT);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.face  <= face_id;
      out_data.level <= level_next;
      out_data.bad   <= bad_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cqfn_split.sv
`default_nettype none

module cqfn_split import cqfn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lvl_stage_t   in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output split_stage_t out_data
);

  face_t          base;
  face_t          offset;
  face_t          root_bits;
  logic [LVL_W:0] shift;
  coord_t         row_bits;
  coord_t         col_bits;
  coord_t         mask;
  cell_t          cell_next;

  // Select the start of the item's level.
  always_comb begin
    base = '0;
    for (int k = 0; k <= MAX_DEPTH; k++) begin
      if (in_data.level == LVL_W'(k)) begin
        base = level_base(k);
      end
    end
  end

  // The offset within the level holds the root above the child digits; each
  // digit carries one row bit over one column bit.
  always_comb begin
    offset    = in_data.face - base;
    shift     = {in_data.level, 1'b0};
    root_bits = offset >> shift;
    for (int i = 0; i < COORD_W; i++) begin
      col_bits[i] = offset[2*i];
      row_bits[i] = offset[2*i+1];
    end
    mask           = level_mask(in_data.level);
    cell_next.root = root_bits[ROOT_W-1:0];
    cell_next.row  = row_bits & mask;
    cell_next.col  = col_bits & mask;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.tile  <= cell_next;
      out_data.level <= in_data.level;
      out_data.bad   <= in_data.bad;
    end
  end

  // A face inside the index range sits on one of the six roots, on its grid.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bad |->
      out_data.tile.root < ROOT_W'(NUM_ROOTS) &&
      (out_data.tile.row >> out_data.level) == '0 &&
      (out_data.tile.col >> out_data.level) == '0)
    else $error("split cell lies off the root grid");

endmodule

`default_nettype wire

FILE: hw/rtl/cqfn_step.sv
`default_nettype none

module cqfn_step import cqfn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  split_stage_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output nbr_stage_t   out_data
);

  cell_t                c;
  coord_t               last;
  cell_t [NUM_DIRS-1:0] nbr_next;
  logic                 nbr_ok;

  function automatic coord_t src_value(input src_t src, input coord_t row,
                                       input coord_t col, input coord_t lst);
    coord_t v;
    unique case (src)
      SRC_ZERO:    v = '0;
      SRC_ROW:     v = row;
      SRC_COL:     v = col;
      SRC_LAST:    v = lst;
      SRC_ROW_REV: v = lst - row;
      SRC_COL_REV: v = lst - col;
      default:     v = '0;
    endcase
    return v;
  endfunction

  // Cell on the adjacent root face reached across a cube edge.
  function automatic cell_t hop(input dir_t dir, input cell_t cur, input coord_t lst);
    edge_hop_t h;
    cell_t     r;
    h      = HOP_TABLE[dir][cur.root];
    r.root = h.root;
    r.row  = src_value(h.row_src, cur.row, cur.col, lst);
    r.col  = src_value(h.col_src, cur.row, cur.col, lst);
    return r;
  endfunction

  // Step one cell in each direction, crossing an edge at the grid border.
  always_comb begin
    c    = in_data.tile;
    last = level_mask(in_data.level);
    nbr_next[DIR_UP]    = (c.row != '0) ?
                          cell_t'{c.root, c.row - coord_t'(1), c.col} :
                          hop(DIR_UP, c, last);
    nbr_next[DIR_DOWN]  = (c.row != last) ?
                          cell_t'{c.root, c.row + coord_t'(1), c.col} :
                          hop(DIR_DOWN, c, last);
    nbr_next[DIR_RIGHT] = (c.col != '0) ?
                          cell_t'{c.root, c.row, c.col - coord_t'(1)} :
                          hop(DIR_RIGHT, c, last);
    nbr_next[DIR_LEFT]  = (c.col != last) ?
                          cell_t'{c.root, c.row, c.col + coord_t'(1)} :
                          hop(DIR_LEFT, c, last);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.nbr   <= nbr_next;
      out_data.level <= in_data.level;
      out_data.bad   <= in_data.bad;
    end
  end

  // Every neighbor stays on a real root and on the grid of the same level.
  always_comb begin
    nbr_ok = 1'b1;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (out_data.nbr[d].root >= ROOT_W'(NUM_ROOTS) ||
          (out_data.nbr[d].row >> out_data.level) != '0 ||
          (out_data.nbr[d].col >> out_data.level) != '0) begin
        nbr_ok = 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bad |-> nbr_ok)
    else $error("neighbor cell lies off the root grid");

endmodule

`default_nettype wire

FILE: hw/rtl/cqfn_compose.sv
`default_nettype none

module cqfn_compose import cqfn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nbr_stage_t           in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output face_t [NUM_DIRS-1:0] nbr_face,
  output logic                 bad
);

  face_t                base;
  logic [LVL_W:0]       shift;
  face_t [NUM_DIRS-1:0] face_next;

  // Child digits, most significant level first: row bit over column bit.
  function automatic face_t interleave(input coord_t row, input coord_t col);
    face_t v;
    v = '0;
    for (int i = 0; i < COORD_W; i++) begin
      v[2*i]   = col[i];
      v[2*i+1] = row[i];
    end
    return v;
  endfunction

  always_comb begin
    base = '0;
    for (int k = 0; k <= MAX_DEPTH; k++) begin
      if (in_data.level == LVL_W'(k)) begin
        base = level_base(k);
      end
    end
  end

  // Face index = level start + root above the digits; a bad item gives zero.
  always_comb begin
    shift = {in_data.level, 1'b0};
    for (int d = 0; d < NUM_DIRS; d++) begin
      face_next[d] = base + ((FACE_W'(in_data.nbr[d].root) << shift) |
                             interleave(in_data.nbr[d].row, in_data.nbr[d].col));
      if (in_data.bad) begin
        face_next[d] = '0;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      nbr_face <= face_next;
      bad      <= in_data.bad;
    end
  end

endmodule

`default_nettype wire
